// ===== rtl/rpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_pkg
// Shared types and constants of the randomized prim maze carver.
// ----------------------------------------------------------------------------
package rpm_pkg;

  localparam int RAND_W      = 16;
  localparam int CFG_W       = 6;
  localparam int COORD_OUT_W = 5;
  localparam int DOOR_W      = 4;
  localparam int CNT_OUT_W   = 11;
  localparam int FLAG_W      = 6;
  localparam int STATUS_W    = 2;

  // register indexes of the configuration port
  localparam logic REG_MAZE_WIDTH  = 1'b0;
  localparam logic REG_MAZE_LENGTH = 1'b1;

  // cell flag bits
  localparam logic [DOOR_W-1:0] DOOR_TOP   = 4'd1;
  localparam logic [DOOR_W-1:0] DOOR_DOWN  = 4'd2;
  localparam logic [DOOR_W-1:0] DOOR_LEFT  = 4'd4;
  localparam logic [DOOR_W-1:0] DOOR_RIGHT = 4'd8;
  localparam logic [FLAG_W-1:0] FLAG_VISITED  = 6'h10;
  localparam logic [FLAG_W-1:0] FLAG_FRONTIER = 6'h20;

  // neighbour directions in test order
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef enum logic [1:0] {
    RES_OK    = 2'd0,
    RES_CFG   = 2'd1,
    RES_EMPTY = 2'd2
  } res_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_DIV_COL,
    OP_TAKE_COL,
    OP_DIV_ROW,
    OP_TAKE_ROW,
    OP_DIV_PICK,
    OP_TAKE_PICK,
    OP_PICK_POS,
    OP_SHIFT,
    OP_NB_RD,
    OP_NB_CAP,
    OP_DIV_NBR,
    OP_TAKE_NBR,
    OP_NO_LINK,
    OP_WR_CELL,
    OP_WR_LINK,
    OP_APPEND,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e  op;
    res_e res;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic cfg_zero;
    logic front_empty;
    logic clr_last;
    logic div_busy;
    logic shift_done;
    logic dir_last;
    logic vis_none;
    logic out_hold;
  } stat_t;

  function automatic logic [DOOR_W-1:0] door_of(input logic [1:0] dir);
    logic [DOOR_W-1:0] d;
    unique case (dir)
      DIR_LEFT:  d = DOOR_LEFT;
      DIR_RIGHT: d = DOOR_RIGHT;
      DIR_UP:    d = DOOR_TOP;
      default:   d = DOOR_DOWN;
    endcase
    return d;
  endfunction

  function automatic logic [DOOR_W-1:0] opp_of(input logic [1:0] dir);
    logic [DOOR_W-1:0] d;
    unique case (dir)
      DIR_LEFT:  d = DOOR_RIGHT;
      DIR_RIGHT: d = DOOR_LEFT;
      DIR_UP:    d = DOOR_DOWN;
      default:   d = DOOR_TOP;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/rpm_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_divider
// Restoring radix-2 divider, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module rpm_divider #(
  parameter int DW = 16,
  parameter int VW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [VW-1:0] rem_o
);

  localparam int CNTW = $clog2(DW);

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dv_q;
  logic [VW:0]     trial;
  logic [VW:0]     diff;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNTW'(DW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_q << 1;
      if (trial >= {1'b0, dv_q}) begin
        rem_q <= diff[VW-1:0];
      end else begin
        rem_q <= trial[VW-1:0];
      end
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/rpm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_datapath
// Cell store, frontier list, counters, divider and result register.
// ----------------------------------------------------------------------------
module rpm_datapath #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rpm_pkg::cmd_t                        cmd_i,
  output rpm_pkg::stat_t                       stat_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [rpm_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 start_req_i,
  input  logic [rpm_pkg::RAND_W-1:0]           rand_a_i,
  input  logic [rpm_pkg::RAND_W-1:0]           rand_b_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [rpm_pkg::COORD_OUT_W-1:0]      cell_x_o,
  output logic [rpm_pkg::COORD_OUT_W-1:0]      cell_y_o,
  output logic [rpm_pkg::DOOR_W-1:0]           cell_doors_o,
  output logic [rpm_pkg::COORD_OUT_W-1:0]      link_x_o,
  output logic [rpm_pkg::COORD_OUT_W-1:0]      link_y_o,
  output logic [rpm_pkg::DOOR_W-1:0]           link_doors_o,
  output logic [rpm_pkg::CNT_OUT_W-1:0]        frontier_left_o,
  output logic [rpm_pkg::CNT_OUT_W-1:0]        cells_done_o,
  output logic                                 finished_o,
  output logic [rpm_pkg::STATUS_W-1:0]         status_o
);

  import rpm_pkg::*;

  localparam int XW    = $clog2(MAX_COLS);
  localparam int YW    = $clog2(MAX_ROWS);
  localparam int AW    = XW + YW;
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int LW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int GXW   = $clog2(MAX_COLS + 1);
  localparam int GYW   = $clog2(MAX_ROWS + 1);

  // configuration and grid
  logic [CFG_W-1:0] width_q, length_q;
  logic [GXW-1:0]   gw_q, w_sat;
  logic [GYW-1:0]   gl_q, l_sat;

  // item and working registers
  logic                start_q;
  logic [RAND_W-1:0]   ra_q, rb_q;
  logic [AW-1:0]       clr_ptr_q;
  logic [CW-1:0]       fcount_q, mcount_q;
  logic [XW-1:0]       cx_q, lx_q;
  logic [YW-1:0]       cy_q, ly_q;
  logic [DOOR_W-1:0]   door_q;
  logic                linked_q;
  logic [FLAG_W-1:0]   lflags_q;
  logic [FLAG_W-1:0]   nf_q [4];
  logic [1:0]          dir_q;
  logic [CW-1:0]       ptr_q;
  logic [LW-1:0]       wa_q;
  logic                pend_q;

  // memories
  logic [FLAG_W-1:0]   flags_mem [2**AW];
  logic [FLAG_W-1:0]   flags_rd_q;
  logic [AW-1:0]       list_mem [CELLS];
  logic [AW-1:0]       list_rd_q;

  // neighbour geometry
  logic [XW-1:0] nx [4];
  logic [YW-1:0] ny [4];
  logic [AW-1:0] nb_addr [4];
  logic [3:0]    inb, vis;
  logic [2:0]    n_vis;
  logic [1:0]    sel;
  logic          found;
  logic [2:0]    seen;
  logic          app_ok;
  logic          issue;

  // divider
  logic              div_go, div_busy;
  logic [RAND_W-1:0] div_a;
  logic [CW-1:0]     div_v, div_rem;

  // flag memory write port
  logic              fl_we;
  logic [AW-1:0]     fl_wa;
  logic [FLAG_W-1:0] fl_wd;

  logic [6:0]  w7, l7, cx7, cy7, lx7, ly7;
  logic [15:0] fc16, mc16;

  assign w7    = 7'(width_q);
  assign l7    = 7'(length_q);
  assign w_sat = (w7 > 7'(MAX_COLS)) ? GXW'(MAX_COLS) : GXW'(width_q);
  assign l_sat = (l7 > 7'(MAX_ROWS)) ? GYW'(MAX_ROWS) : GYW'(length_q);

  always_comb begin
    nx[DIR_LEFT]  = cx_q - 1'b1;
    ny[DIR_LEFT]  = cy_q;
    nx[DIR_RIGHT] = cx_q + 1'b1;
    ny[DIR_RIGHT] = cy_q;
    nx[DIR_UP]    = cx_q;
    ny[DIR_UP]    = cy_q - 1'b1;
    nx[DIR_DOWN]  = cx_q;
    ny[DIR_DOWN]  = cy_q + 1'b1;
    inb[DIR_LEFT]  = (cx_q != '0);
    inb[DIR_RIGHT] = (7'(cx_q) + 7'd1) < 7'(gw_q);
    inb[DIR_UP]    = (cy_q != '0);
    inb[DIR_DOWN]  = (7'(cy_q) + 7'd1) < 7'(gl_q);
    for (int d = 0; d < 4; d++) begin
      nb_addr[d] = {ny[d], nx[d]};
      vis[d]     = inb[d] & nf_q[d][4];
    end
  end

  assign n_vis = 3'(vis[0]) + 3'(vis[1]) + 3'(vis[2]) + 3'(vis[3]);

  // c-th visited neighbour in test order
  always_comb begin
    sel   = DIR_LEFT;
    found = 1'b0;
    seen  = '0;
    for (int d = 0; d < 4; d++) begin
      if (vis[d] && !found) begin
        if (seen == {1'b0, div_rem[1:0]}) begin
          sel   = 2'(d);
          found = 1'b1;
        end
        seen = seen + 1'b1;
      end
    end
  end

  assign app_ok = inb[dir_q] && (nf_q[dir_q] == '0) && (fcount_q < CW'(CELLS));
  assign issue  = (ptr_q <= fcount_q);

  // divider operand select
  always_comb begin
    div_go = 1'b0;
    div_a  = ra_q;
    div_v  = fcount_q;
    unique case (cmd_i.op)
      OP_DIV_COL: begin
        div_go = 1'b1;
        div_v  = CW'(gw_q);
      end
      OP_DIV_ROW: begin
        div_go = 1'b1;
        div_a  = rb_q;
        div_v  = CW'(gl_q);
      end
      OP_DIV_PICK: begin
        div_go = 1'b1;
      end
      OP_DIV_NBR: begin
        div_go = 1'b1;
        div_a  = rb_q;
        div_v  = CW'(n_vis);
      end
      default: ;
    endcase
  end

  rpm_divider #(
    .DW(RAND_W),
    .VW(CW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .go_i       (div_go),
    .dividend_i (div_a),
    .divisor_i  (div_v),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // flag memory write select
  always_comb begin
    fl_we = 1'b0;
    fl_wa = clr_ptr_q;
    fl_wd = '0;
    unique case (cmd_i.op)
      OP_CLR_STEP: fl_we = 1'b1;
      OP_WR_CELL: begin
        fl_we = 1'b1;
        fl_wa = {cy_q, cx_q};
        fl_wd = FLAG_VISITED | (start_q ? '0 : FLAG_FRONTIER) | FLAG_W'(door_q);
      end
      OP_WR_LINK: begin
        fl_we = linked_q;
        fl_wa = {ly_q, lx_q};
        fl_wd = lflags_q;
      end
      OP_APPEND: begin
        fl_we = app_ok;
        fl_wa = nb_addr[dir_q];
        fl_wd = FLAG_FRONTIER;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fl_we) begin
      flags_mem[fl_wa] <= fl_wd;
    end
    if (cmd_i.op == OP_NB_RD) begin
      flags_rd_q <= flags_mem[nb_addr[dir_q]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SHIFT && pend_q) begin
      list_mem[wa_q] <= list_rd_q;
    end else if (cmd_i.op == OP_APPEND && app_ok) begin
      list_mem[LW'(fcount_q)] <= nb_addr[dir_q];
    end
    if (cmd_i.op == OP_TAKE_PICK) begin
      list_rd_q <= list_mem[LW'(div_rem)];
    end else if (cmd_i.op == OP_SHIFT && issue) begin
      list_rd_q <= list_mem[LW'(ptr_q)];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= '0;
      length_q    <= '0;
      gw_q        <= '0;
      gl_q        <= '0;
      fcount_q    <= '0;
      mcount_q    <= '0;
      clr_ptr_q   <= '0;
      dir_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == REG_MAZE_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == REG_MAZE_LENGTH) begin
        length_q <= cfg_data_i;
      end
      if (cmd_i.op == OP_RESULT) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_CLR_INIT: begin
          clr_ptr_q <= '0;
          fcount_q  <= '0;
          mcount_q  <= '0;
          gw_q      <= w_sat;
          gl_q      <= l_sat;
        end
        OP_CLR_STEP:  clr_ptr_q <= clr_ptr_q + 1'b1;
        OP_TAKE_ROW:  dir_q <= '0;
        OP_TAKE_PICK: pend_q <= 1'b0;
        OP_PICK_POS: begin
          fcount_q <= fcount_q - 1'b1;
          dir_q    <= '0;
        end
        OP_SHIFT:     pend_q <= issue;
        OP_NB_CAP:    dir_q <= dir_q + 1'b1;
        OP_WR_CELL:   mcount_q <= mcount_q + 1'b1;
        OP_APPEND: begin
          dir_q <= dir_q + 1'b1;
          if (app_ok) begin
            fcount_q <= fcount_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign cx7  = 7'(cx_q);
  assign cy7  = 7'(cy_q);
  assign lx7  = 7'(lx_q);
  assign ly7  = 7'(ly_q);
  assign fc16 = 16'(fcount_q);
  assign mc16 = 16'(mcount_q);

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        start_q <= start_req_i;
        ra_q    <= rand_a_i;
        rb_q    <= rand_b_i;
      end
      OP_TAKE_COL: cx_q <= XW'(div_rem);
      OP_TAKE_ROW: begin
        cy_q     <= YW'(div_rem);
        lx_q     <= cx_q;
        ly_q     <= YW'(div_rem);
        door_q   <= '0;
        linked_q <= 1'b0;
        for (int d = 0; d < 4; d++) begin
          nf_q[d] <= '0;
        end
      end
      OP_TAKE_PICK: ptr_q <= div_rem + 1'b1;
      OP_PICK_POS:  {cy_q, cx_q} <= list_rd_q;
      OP_SHIFT: begin
        if (issue) begin
          wa_q  <= LW'(ptr_q - 1'b1);
          ptr_q <= ptr_q + 1'b1;
        end
      end
      OP_NB_CAP:  nf_q[dir_q] <= flags_rd_q;
      OP_NO_LINK: begin
        lx_q     <= cx_q;
        ly_q     <= cy_q;
        door_q   <= '0;
        linked_q <= 1'b0;
      end
      OP_TAKE_NBR: begin
        lx_q     <= nx[sel];
        ly_q     <= ny[sel];
        door_q   <= door_of(sel);
        lflags_q <= nf_q[sel] | FLAG_W'(opp_of(sel));
        linked_q <= 1'b1;
      end
      OP_RESULT: begin
        frontier_left_o <= fc16[CNT_OUT_W-1:0];
        cells_done_o    <= mc16[CNT_OUT_W-1:0];
        finished_o      <= (fcount_q == '0) && (mcount_q != '0);
        status_o        <= cmd_i.res;
        if (cmd_i.res == RES_OK) begin
          cell_x_o     <= cx7[COORD_OUT_W-1:0];
          cell_y_o     <= cy7[COORD_OUT_W-1:0];
          cell_doors_o <= door_q;
          link_x_o     <= lx7[COORD_OUT_W-1:0];
          link_y_o     <= ly7[COORD_OUT_W-1:0];
          link_doors_o <= linked_q ? lflags_q[DOOR_W-1:0] : door_q;
        end else begin
          cell_x_o     <= '0;
          cell_y_o     <= '0;
          cell_doors_o <= '0;
          link_x_o     <= '0;
          link_y_o     <= '0;
          link_doors_o <= '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.start       = start_q;
    stat_o.cfg_zero    = (w_sat == '0) || (l_sat == '0);
    stat_o.front_empty = (fcount_q == '0);
    stat_o.clr_last    = (clr_ptr_q == '1);
    stat_o.div_busy    = div_busy;
    stat_o.shift_done  = !pend_q && !issue;
    stat_o.dir_last    = (dir_q == DIR_DOWN);
    stat_o.vis_none    = (vis == 4'b0000);
    stat_o.out_hold    = out_valid_o && out_stall_i;
  end

endmodule

// ===== rtl/rpm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_ctrl
// Sequencer that steps the datapath through one start or one iteration.
// ----------------------------------------------------------------------------
module rpm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rpm_pkg::stat_t stat_i,
  output rpm_pkg::cmd_t  cmd_o
);

  import rpm_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_CLEAR  = 5'd2;
  localparam logic [4:0] S_COL    = 5'd3;
  localparam logic [4:0] S_DIVW   = 5'd4;
  localparam logic [4:0] S_ROW    = 5'd5;
  localparam logic [4:0] S_ROW2   = 5'd6;
  localparam logic [4:0] S_STCELL = 5'd7;
  localparam logic [4:0] S_PICK   = 5'd8;
  localparam logic [4:0] S_POS    = 5'd9;
  localparam logic [4:0] S_SHIFT  = 5'd10;
  localparam logic [4:0] S_NBRD   = 5'd11;
  localparam logic [4:0] S_NBCAP  = 5'd12;
  localparam logic [4:0] S_NBSEL  = 5'd13;
  localparam logic [4:0] S_LINK   = 5'd14;
  localparam logic [4:0] S_WRC    = 5'd15;
  localparam logic [4:0] S_WRL    = 5'd16;
  localparam logic [4:0] S_APP    = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;

  logic [4:0] state_q, state_d;
  logic [4:0] ret_q, ret_d;
  res_e       res_q, res_d;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    res_d     = res_q;
    cmd_o.op  = OP_NONE;
    cmd_o.res = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat_i.start && stat_i.cfg_zero) begin
          res_d   = RES_CFG;
          state_d = S_DONE;
        end else if (stat_i.start) begin
          cmd_o.op = OP_CLR_INIT;
          state_d  = S_CLEAR;
        end else if (stat_i.front_empty) begin
          res_d   = RES_EMPTY;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_DIV_PICK;
          ret_d    = S_PICK;
          state_d  = S_DIVW;
        end
      end
      S_CLEAR: begin
        cmd_o.op = OP_CLR_STEP;
        if (stat_i.clr_last) begin
          state_d = S_COL;
        end
      end
      S_COL: begin
        cmd_o.op = OP_DIV_COL;
        ret_d    = S_ROW;
        state_d  = S_DIVW;
      end
      S_DIVW: begin
        if (!stat_i.div_busy) begin
          state_d = ret_q;
        end
      end
      S_ROW: begin
        cmd_o.op = OP_TAKE_COL;
        state_d  = S_ROW2;
      end
      S_ROW2: begin
        cmd_o.op = OP_DIV_ROW;
        ret_d    = S_STCELL;
        state_d  = S_DIVW;
      end
      S_STCELL: begin
        cmd_o.op = OP_TAKE_ROW;
        state_d  = S_WRC;
      end
      S_PICK: begin
        cmd_o.op = OP_TAKE_PICK;
        state_d  = S_POS;
      end
      S_POS: begin
        cmd_o.op = OP_PICK_POS;
        state_d  = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.op = OP_SHIFT;
        if (stat_i.shift_done) begin
          state_d = S_NBRD;
        end
      end
      S_NBRD: begin
        cmd_o.op = OP_NB_RD;
        state_d  = S_NBCAP;
      end
      S_NBCAP: begin
        cmd_o.op = OP_NB_CAP;
        state_d  = stat_i.dir_last ? S_NBSEL : S_NBRD;
      end
      S_NBSEL: begin
        if (stat_i.vis_none) begin
          cmd_o.op = OP_NO_LINK;
          state_d  = S_WRC;
        end else begin
          cmd_o.op = OP_DIV_NBR;
          ret_d    = S_LINK;
          state_d  = S_DIVW;
        end
      end
      S_LINK: begin
        cmd_o.op = OP_TAKE_NBR;
        state_d  = S_WRC;
      end
      S_WRC: begin
        cmd_o.op = OP_WR_CELL;
        state_d  = S_WRL;
      end
      S_WRL: begin
        cmd_o.op = OP_WR_LINK;
        state_d  = S_APP;
      end
      S_APP: begin
        cmd_o.op = OP_APPEND;
        if (stat_i.dir_last) begin
          res_d   = RES_OK;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.out_hold) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      res_q   <= RES_OK;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      res_q   <= res_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== rtl/random_prim_maze_carver.sv =====
`timescale 1ns / 1ps
// a start clears the cell store, then takes two remainder passes through the divider (column, row)
// an iteration runs the one-entry-a-cycle frontier shift and one or two remainder passes
//   (pick, then neighbour) through the shared divider
// one transaction in flight; the result register frees the input while it waits
// reset clears control, counts and size registers; the cell store is cleared by each start
// ----------------------------------------------------------------------------
// random_prim_maze_carver
// Randomized prim maze generator over a grid of up to MAX_COLS x MAX_ROWS cells.
// ----------------------------------------------------------------------------
module random_prim_maze_carver #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [rpm_pkg::CFG_W-1:0]       cfg_data_i,
  // input transaction
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            start_req_i,
  input  logic [rpm_pkg::RAND_W-1:0]      rand_a_i,
  input  logic [rpm_pkg::RAND_W-1:0]      rand_b_i,
  // result transaction
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rpm_pkg::COORD_OUT_W-1:0] cell_x_o,
  output logic [rpm_pkg::COORD_OUT_W-1:0] cell_y_o,
  output logic [rpm_pkg::DOOR_W-1:0]      cell_doors_o,
  output logic [rpm_pkg::COORD_OUT_W-1:0] link_x_o,
  output logic [rpm_pkg::COORD_OUT_W-1:0] link_y_o,
  output logic [rpm_pkg::DOOR_W-1:0]      link_doors_o,
  output logic [rpm_pkg::CNT_OUT_W-1:0]   frontier_left_o,
  output logic [rpm_pkg::CNT_OUT_W-1:0]   cells_done_o,
  output logic                            finished_o,
  output logic [rpm_pkg::STATUS_W-1:0]    status_o
);

  import rpm_pkg::*;

  // sequencer commands one datapath operation per cycle while not waiting; reads back flags
  cmd_t  cmd;
  stat_t stat;

  rpm_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // datapath: cell flag store, ordered frontier list, divider, result register
  rpm_datapath #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .start_req_i,
    .rand_a_i,
    .rand_b_i,
    .out_stall_i,
    .out_valid_o,
    .cell_x_o,
    .cell_y_o,
    .cell_doors_o,
    .link_x_o,
    .link_y_o,
    .link_doors_o,
    .frontier_left_o,
    .cells_done_o,
    .finished_o,
    .status_o
  );

endmodule
